// File: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SSTF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSTF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/sstf_pkg.sv
// Types and constants of the shortest-seek-first request scheduler.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sstf_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned REQ_TRACK_W = 8;
  localparam int unsigned SEEK_W      = 8;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned MOVE_W      = 14;
  localparam int unsigned DLEN_W      = 6;
  localparam int unsigned DCNT_W      = 7;
  localparam int unsigned DSUM_W      = 12;

  // Head movement total saturates here.
  localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

  // One request transaction.
  typedef struct packed {
    logic [REQ_TRACK_W-1:0] req_track;
    logic                   last_request;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [REQ_TRACK_W-1:0] served_track;
    logic [SEEK_W-1:0]      seek_distance;
    logic [POS_W-1:0]       served_position;
    logic                   last_result;
    logic [MOVE_W-1:0]      total_movement;
    logic [REQ_TRACK_W-1:0] longest_delay_track;
    logic [DLEN_W-1:0]      longest_delay_length;
    logic [DCNT_W-1:0]      delayed_count;
    logic [DSUM_W-1:0]      total_delay;
  } res_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PICK_INIT,
    ST_PICK_HEAD,
    ST_SCAN,
    ST_PICK_DONE,
    ST_TALLY_RD,
    ST_TALLY_CHK,
    ST_TALLY_SCAN,
    ST_TALLY_UPD,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_e;

endpackage

`default_nettype wire

// File: rtl/sstf_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sstf_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sstf_req_if import sstf_pkg::*;;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sstf_res_if import sstf_pkg::*;;
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/sstf_cmp_unit.sv
// Shared compare unit: absolute track distance, equality and closer-than test.
// Standalone; instantiated once by the scheduler top level.
`timescale 1ns / 1ps
`default_nettype none

module sstf_cmp_unit #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic [WIDTH-1:0] op_a_i,
  input  wire logic [WIDTH-1:0] op_b_i,
  input  wire logic [WIDTH-1:0] best_i,
  output logic      [WIDTH-1:0] dist_o,
  output logic                  eq_o,
  output logic                  closer_o
);

  logic a_below;

  // Distance is the magnitude of the difference between the operands.
  assign a_below  = op_a_i < op_b_i;
  assign dist_o   = a_below ? (op_b_i - op_a_i) : (op_a_i - op_b_i);
  assign eq_o     = op_a_i == op_b_i;
  assign closer_o = dist_o < best_i;

endmodule

`default_nettype wire

// File: rtl/sstf_disk_request_scheduler_core.sv
// Shortest-seek-first request scheduler, top level.
//
// Requests arrive on req_i, one track per transaction, in arrival order; the
// first one of a batch sets the starting head position. Requests load at one
// per cycle while ready is high. The transaction with last_request set closes
// the batch; the block then drops ready and builds the schedule. Requests
// beyond the store capacity are dropped, but a dropped closing request still
// starts scheduling. With n stored requests, each of the n picks walks the
// store through the shared compare unit at one entry per cycle. The delay
// tally then checks each request in arrival order and, for each request
// served out of place, walks the service order for its first service slot.
// Results then leave on res_o one at a time while the receiver keeps ready
// high; a stall simply holds the output register and the sequencer.
// The last result carries the totals. Loading of the next batch starts as
// soon as the last result sits in the output register.
// Reset clears the batch, the served flags and the statistics at once; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sstf_disk_request_scheduler_core
  import sstf_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = 64,
  parameter int unsigned TRACK_BITS   = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sstf_req_if.sink    req_i,
  sstf_res_if.source  res_o
);

`include "assert_macros.svh"

  localparam int unsigned IDX_W = $clog2(MAX_REQUESTS);
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned SUM_W = ((TRACK_BITS > MOVE_W) ? TRACK_BITS : MOVE_W) + 1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  state_e state_q, state_d;

  // Batch control.
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        n_q;
  logic [MAX_REQUESTS-1:0] served_q;
  logic [CNT_W-1:0]        scan_q;
  logic [IDX_W-1:0]        k_q;
  logic [IDX_W-1:0]        ti_q;
  logic                    found_q;
  logic                    mfound_q;

  // Statistics.
  logic [MOVE_W-1:0]     move_q;
  logic [TRACK_BITS-1:0] wtrack_q;
  logic [IDX_W-1:0]      wlen_q;
  logic [DCNT_W-1:0]     dcnt_q;
  logic [DSUM_W-1:0]     dsum_q;

  // Datapath registers.
  logic [TRACK_BITS-1:0] head_q;
  logic [TRACK_BITS-1:0] best_d_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [TRACK_BITS-1:0] best_track_q;
  logic [TRACK_BITS-1:0] t_q;
  logic [IDX_W-1:0]      match_j_q;
  logic                  res_vld_q;
  res_t                  res_q;

  // Memories and their registered read data.
  logic [TRACK_BITS-1:0] store_mem [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] order_mem [MAX_REQUESTS];
  logic [SEEK_W-1:0]     seek_mem  [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] store_rd_q;
  logic [TRACK_BITS-1:0] order_rd_q;
  logic [SEEK_W-1:0]     seek_rd_q;
  logic [IDX_W-1:0]      store_raddr;
  logic [IDX_W-1:0]      order_raddr;

  // Control strobes and shared unit connections.
  logic                  req_rdy;
  logic                  req_acc;
  logic                  store_full;
  logic                  scan_last;
  logic                  cmp_vld;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  k_last;
  logic                  tally_last;
  logic                  out_free;
  logic                  take;
  logic                  take_match;
  logic [TRACK_BITS-1:0] op_a;
  logic [TRACK_BITS-1:0] op_b;
  logic [TRACK_BITS-1:0] seek_dist;
  logic                  eq;
  logic                  closer;
  logic [SUM_W-1:0]      move_sum;
  logic [MOVE_W-1:0]     move_next;
  logic [IDX_W-1:0]      delay;

  // Shared distance and compare unit.
  sstf_cmp_unit #(
    .WIDTH (TRACK_BITS)
  ) u_cmp (
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .best_i   (best_d_q),
    .dist_o   (seek_dist),
    .eq_o     (eq),
    .closer_o (closer)
  );

  // Status terms used by both the sequencer and the datapath.
  assign req_rdy    = state_q == ST_LOAD;
  assign req_acc    = req_i.valid && req_rdy;
  assign store_full = count_q == CNT_MAX;
  assign scan_last  = scan_q == n_q;
  assign cmp_vld    = scan_q != '0;
  assign cmp_idx    = IDX_W'(scan_q - CNT_ONE);
  assign k_last     = CNT_W'(k_q) == (n_q - CNT_ONE);
  assign tally_last = CNT_W'(ti_q) == (n_q - CNT_ONE);
  assign out_free   = !res_vld_q || res_o.ready;
  assign move_sum   = SUM_W'(move_q) + SUM_W'(best_d_q);
  assign move_next  = (move_sum > SUM_W'(MOVE_MAX)) ? MOVE_MAX : MOVE_W'(move_sum);
  assign delay      = match_j_q - ti_q;

  assign req_i.ready   = req_rdy;
  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (req_acc && req_i.payload.last_request) state_d = ST_PICK_INIT;
      end
      ST_PICK_INIT: state_d = ST_PICK_HEAD;
      ST_PICK_HEAD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_d = ST_PICK_DONE;
      end
      ST_PICK_DONE: state_d = k_last ? ST_TALLY_RD : ST_SCAN;
      ST_TALLY_RD:  state_d = ST_TALLY_CHK;
      ST_TALLY_CHK: begin
        if (!eq) begin
          state_d = ST_TALLY_SCAN;
        end else begin
          state_d = tally_last ? ST_EMIT_RD : ST_TALLY_RD;
        end
      end
      ST_TALLY_SCAN: begin
        if (scan_last) state_d = ST_TALLY_UPD;
      end
      ST_TALLY_UPD: state_d = tally_last ? ST_EMIT_RD : ST_TALLY_RD;
      ST_EMIT_RD:   state_d = ST_EMIT_LOAD;
      ST_EMIT_LOAD: begin
        if (out_free) state_d = k_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Sequencer outputs: read addresses, compare operands and pick strobes.
  always_comb begin
    store_raddr = '0;
    order_raddr = k_q;
    op_a        = head_q;
    op_b        = store_rd_q;
    take        = 1'b0;
    take_match  = 1'b0;
    unique case (state_q)
      ST_SCAN: begin
        store_raddr = scan_q[IDX_W-1:0];
        take = cmp_vld && !served_q[cmp_idx] && (!found_q || closer);
      end
      ST_TALLY_RD: begin
        store_raddr = ti_q;
        order_raddr = ti_q;
      end
      ST_TALLY_CHK: begin
        op_a = store_rd_q;
        op_b = order_rd_q;
      end
      ST_TALLY_SCAN: begin
        order_raddr = scan_q[IDX_W-1:0];
        op_a        = order_rd_q;
        op_b        = t_q;
        take_match  = cmp_vld && !mfound_q && eq;
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Batch control, counters and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      n_q       <= '0;
      served_q  <= '0;
      scan_q    <= '0;
      k_q       <= '0;
      ti_q      <= '0;
      found_q   <= 1'b0;
      mfound_q  <= 1'b0;
      move_q    <= '0;
      wtrack_q  <= '0;
      wlen_q    <= '0;
      dcnt_q    <= '0;
      dsum_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      // The result register refills from the emit step or empties on a transaction.
      if ((state_q == ST_EMIT_LOAD) && out_free) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (req_acc) begin
            if (!store_full) count_q <= count_q + CNT_ONE;
            if (req_i.payload.last_request) begin
              n_q      <= store_full ? count_q : (count_q + CNT_ONE);
              served_q <= '0;
              move_q   <= '0;
              wtrack_q <= '0;
              wlen_q   <= '0;
              dcnt_q   <= '0;
              dsum_q   <= '0;
            end
          end
        end
        ST_PICK_HEAD: begin
          k_q     <= '0;
          scan_q  <= '0;
          found_q <= 1'b0;
        end
        ST_SCAN: begin
          scan_q <= scan_q + CNT_ONE;
          if (take) found_q <= 1'b1;
        end
        ST_PICK_DONE: begin
          served_q[best_idx_q] <= 1'b1;
          move_q <= move_next;
          if (k_last) begin
            ti_q <= '0;
          end else begin
            k_q     <= k_q + IDX_W'(1);
            scan_q  <= '0;
            found_q <= 1'b0;
          end
        end
        ST_TALLY_CHK: begin
          if (!eq) begin
            scan_q   <= '0;
            mfound_q <= 1'b0;
          end else if (tally_last) begin
            k_q <= '0;
          end else begin
            ti_q <= ti_q + IDX_W'(1);
          end
        end
        ST_TALLY_SCAN: begin
          scan_q <= scan_q + CNT_ONE;
          if (take_match) mfound_q <= 1'b1;
        end
        ST_TALLY_UPD: begin
          // Only a request served later than its arrival slot counts.
          if (match_j_q > ti_q) begin
            dsum_q <= dsum_q + DSUM_W'(delay);
            dcnt_q <= dcnt_q + DCNT_W'(1);
            if (delay > wlen_q) begin
              wlen_q   <= delay;
              wtrack_q <= t_q;
            end
          end
          if (tally_last) begin
            k_q <= '0;
          end else begin
            ti_q <= ti_q + IDX_W'(1);
          end
        end
        ST_EMIT_LOAD: begin
          if (out_free) begin
            if (k_last) begin
              count_q  <= '0;
              served_q <= '0;
            end else begin
              k_q <= k_q + IDX_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Head, best candidate, tally operands and the result register.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_PICK_HEAD: head_q <= store_rd_q;
      ST_SCAN: begin
        if (take) begin
          best_d_q     <= seek_dist;
          best_idx_q   <= cmp_idx;
          best_track_q <= store_rd_q;
        end
      end
      ST_PICK_DONE: head_q <= best_track_q;
      ST_TALLY_CHK: t_q <= store_rd_q;
      ST_TALLY_SCAN: begin
        if (take_match) match_j_q <= cmp_idx;
      end
      ST_EMIT_LOAD: begin
        if (out_free) begin
          res_q.served_track    <= REQ_TRACK_W'(order_rd_q);
          res_q.seek_distance   <= seek_rd_q;
          res_q.served_position <= POS_W'(k_q);
          res_q.last_result     <= k_last;
          if (k_last) begin
            res_q.total_movement       <= move_q;
            res_q.longest_delay_track  <= REQ_TRACK_W'(wtrack_q);
            res_q.longest_delay_length <= DLEN_W'(wlen_q);
            res_q.delayed_count        <= dcnt_q;
            res_q.total_delay          <= dsum_q;
          end else begin
            res_q.total_movement       <= '0;
            res_q.longest_delay_track  <= '0;
            res_q.longest_delay_length <= '0;
            res_q.delayed_count        <= '0;
            res_q.total_delay          <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Request store: written on load, read for the starting head, by the pick scan and by the tally.
  always_ff @(posedge clk_i) begin
    if (req_acc && !store_full) begin
      store_mem[count_q[IDX_W-1:0]] <= TRACK_BITS'(req_i.payload.req_track);
    end
    store_rd_q <= store_mem[store_raddr];
  end

  // Service order and seek distance, written once per pick.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PICK_DONE) begin
      order_mem[k_q] <= best_track_q;
      seek_mem[k_q]  <= SEEK_W'(best_d_q);
    end
    order_rd_q <= order_mem[order_raddr];
    seek_rd_q  <= seek_mem[k_q];
  end

  // Consistency checks of the sequencer.
  `SSTF_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_MAX, "request count beyond capacity")
  `SSTF_ASSERT_IMPLIES(a_pick_found, state_q == ST_PICK_DONE, found_q,
                       "pick finished without an unserved request")
  `SSTF_ASSERT_IMPLIES(a_all_served, (state_q == ST_TALLY_RD) && (ti_q == '0),
                       $countones(served_q) == int'(n_q), "tally started before all were served")
  `SSTF_ASSERT_IMPLIES(a_tally_match, state_q == ST_TALLY_UPD, mfound_q,
                       "served track missing from the service order")

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the shortest-seek-first request scheduler.
// Depends on sstf_pkg, the channel interfaces in sstf_if and the core top level.
`timescale 1ns / 1ps

module tb;
  import sstf_pkg::*;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned TRACK_W      = 8;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned DRAIN_LIMIT  = 50000;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_LIMIT  = 60;

  // Predicts the schedule of each batch and checks the results in order.
  class sstf_schedule_board;
    logic [7:0]  batch [STORE_DEPTH];
    int unsigned stored;
    res_t        expected_q [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      stored     = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    task report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    // Stores one accepted request; a closing request builds the whole schedule.
    function void note_request(req_t rq);
      logic [7:0]  order [STORE_DEPTH];
      bit          taken [STORE_DEPTH];
      res_t        sched [$];
      res_t        r;
      logic [7:0]  head, seek, best_seek, worst_trk;
      int unsigned n, best, moved, worst_len, late_cnt, late_sum, delay;
      bit          found, located;
      // A full store drops the request, but a closing one still schedules.
      if (stored < STORE_DEPTH) begin
        batch[stored] = rq.req_track;
        stored++;
      end
      if (!rq.last_request) return;
      n     = stored;
      head  = batch[0];
      moved = 0;
      foreach (taken[i]) taken[i] = 1'b0;
      // Each pick takes the nearest unserved track, ties to the lowest index.
      for (int k = 0; k < n; k++) begin
        found     = 1'b0;
        best      = 0;
        best_seek = '0;
        for (int i = 0; i < n; i++) begin
          if (taken[i]) continue;
          seek = (head > batch[i]) ? head - batch[i] : batch[i] - head;
          if (!found || seek < best_seek) begin
            found     = 1'b1;
            best_seek = seek;
            best      = i;
          end
        end
        taken[best] = 1'b1;
        order[k]    = batch[best];
        head        = batch[best];
        moved      += 32'(best_seek);
        if (moved > 32'(MOVE_MAX)) moved = 32'(MOVE_MAX);
        r                 = '0;
        r.served_track    = head;
        r.seek_distance   = best_seek;
        r.served_position = POS_W'(k);
        sched.push_back(r);
      end
      // A request is late when the first service slot of its track lies after
      // its arrival slot.
      worst_len = 0;
      worst_trk = '0;
      late_cnt  = 0;
      late_sum  = 0;
      for (int i = 0; i < n; i++) begin
        if (batch[i] == order[i]) continue;
        located = 1'b0;
        for (int j = 0; j < n; j++) begin
          if (!located && order[j] == batch[i]) begin
            located = 1'b1;
            if (j > i) begin
              delay     = j - i;
              late_sum += delay;
              late_cnt++;
              if (delay > worst_len) begin
                worst_len = delay;
                worst_trk = batch[i];
              end
            end
          end
        end
      end
      r                      = sched[n-1];
      r.last_result          = 1'b1;
      r.total_movement       = MOVE_W'(moved);
      r.longest_delay_track  = worst_trk;
      r.longest_delay_length = DLEN_W'(worst_len);
      r.delayed_count        = DCNT_W'(late_cnt);
      r.total_delay          = DSUM_W'(late_sum);
      sched[n-1]             = r;
      foreach (sched[i]) expected_q.push_back(sched[i]);
      stored = 0;
    endfunction

    task compare_field(input string name, input logic [15:0] got, input logic [15:0] want,
                       input int unsigned pos);
      if (got !== want) begin
        report_mismatch($sformatf("position %0d %s: got %0d, expected %0d",
                                  pos, name, got, want));
      end
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(input res_t got);
      res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, track %0d position %0d",
                                  got.served_track, got.served_position));
        return;
      end
      want = expected_q.pop_front();
      compare_field("served_track", 16'(got.served_track), 16'(want.served_track),
                    want.served_position);
      compare_field("seek_distance", 16'(got.seek_distance), 16'(want.seek_distance),
                    want.served_position);
      compare_field("served_position", 16'(got.served_position),
                    16'(want.served_position), want.served_position);
      compare_field("last_result", 16'(got.last_result), 16'(want.last_result),
                    want.served_position);
      compare_field("total_movement", 16'(got.total_movement), 16'(want.total_movement),
                    want.served_position);
      compare_field("longest_delay_track", 16'(got.longest_delay_track),
                    16'(want.longest_delay_track), want.served_position);
      compare_field("longest_delay_length", 16'(got.longest_delay_length),
                    16'(want.longest_delay_length), want.served_position);
      compare_field("delayed_count", 16'(got.delayed_count), 16'(want.delayed_count),
                    want.served_position);
      compare_field("total_delay", 16'(got.total_delay), 16'(want.total_delay),
                    want.served_position);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned cycle_count = 0;

  sstf_req_if req_ch ();
  sstf_res_if res_ch ();

  sstf_schedule_board sb;

  sstf_disk_request_scheduler_core #(
    .MAX_REQUESTS(STORE_DEPTH),
    .TRACK_BITS  (TRACK_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sstf_disk_request_scheduler_core");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request and waits until the transaction is accepted.
  task automatic send_request(input logic [7:0] trk, input logic last, input bit no_gap);
    int unsigned gap;
    req_t        rq;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.req_track    = trk;
    rq.last_request = last;
    req_ch.valid   <= 1'b1;
    req_ch.payload <= rq;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_request(rq);
  endtask

  // Stops offering and waits until every expected result has arrived or the drain limit runs out.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  // Result side: checks each transaction and stalls at random, with one long
  // hold-off that lets the block fill up and stall its input.
  initial begin
    int unsigned stall_left, steady_left;
    bit          held_off;
    stall_left  = 0;
    steady_left = 0;
    held_off    = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
      if (!held_off && sb.checked >= 40) begin
        held_off   = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        res_ch.ready <= 1'b1;
        steady_left--;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_gap();
        if ($urandom_range(0, 7) == 0) steady_left = $urandom_range(30, 150);
      end
    end
  end

  // Request side and end of run.
  initial begin
    logic [7:0]  dir_trk [0:21];
    logic [21:0] dir_last;
    logic [7:0]  trk;
    int unsigned sent, size, style, base, batch_idx;
    bit          no_gap;
    sb = new();
    rst_ni          = 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    // Single-request batches at both extremes, a tie batch, repeated tracks,
    // extreme tracks and a reversed batch with long delays.
    dir_trk  = '{8'd255, 8'd0,
                 8'd100, 8'd90, 8'd110, 8'd95, 8'd105,
                 8'd50, 8'd200, 8'd50, 8'd49, 8'd200,
                 8'd128, 8'd0, 8'd255, 8'd1, 8'd254,
                 8'd0, 8'd255, 8'd10, 8'd5, 8'd3};
    dir_last = 22'b1000010000100001000011;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 22; i++) begin
      send_request(dir_trk[i], dir_last[i], 1'b0);
    end
    drain_results();

    // Random batches: mostly small, two that fill the store, one of them
    // overflowing so that its closing request is dropped.
    sent      = 0;
    batch_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      if (batch_idx == 4) size = STORE_DEPTH + $urandom_range(1, 5);
      else if (batch_idx == 14) size = STORE_DEPTH;
      else if ($urandom_range(0, 5) == 0) size = $urandom_range(11, 24);
      else size = $urandom_range(1, 10);
      style  = $urandom_range(0, 2);
      base   = $urandom_range(0, 249);
      no_gap = ($urandom_range(0, 3) == 0);
      for (int b = 0; b < size; b++) begin
        case (style)
          0: trk = 8'($urandom_range(0, 255));
          1: trk = 8'(base + $urandom_range(0, 6));
          default: begin
            case ($urandom_range(0, 5))
              0: trk = 8'd0;
              1: trk = 8'd1;
              2: trk = 8'd127;
              3: trk = 8'd128;
              4: trk = 8'd254;
              default: trk = 8'd255;
            endcase
          end
        endcase
        send_request(trk, b == size - 1, no_gap);
      end
      sent += size;
      batch_idx++;
      if (batch_idx == 9) drain_results();
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.expected_q.size()));
    end
    if (sb.mismatches == 0) begin
      $display("PASS sstf_disk_request_scheduler_core");
    end else begin
      $display("FAIL sstf_disk_request_scheduler_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sstf_pkg.sv
rtl/sstf_if.sv
rtl/sstf_cmp_unit.sv
rtl/sstf_disk_request_scheduler_core.sv
tb/tb.sv
